[rtl/ffoa_pkg.sv]
// Shared codes for the first-fit offset allocator.
// Holds the request action codes and the result status codes.
// No dependencies.
package ffoa_pkg;

    // Request action
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    // Fixed field widths
    localparam int unsigned FIELD_W  = 32;
    localparam int unsigned STATUS_W = 2;

endpackage

[rtl/first_fit_offset_allocator.sv]
// First-fit offset allocator: a sorted segment table held in two memories.
// Depends on ffoa_pkg for action and status codes.
//
//  channel | direction | handshake                      | words
//  --------+-----------+--------------------------------+------------------------------------
//  request | in        | i_in_valid / o_in_stall        | i_action, i_req_size, i_free_offset
//  result  | out       | o_out_valid / i_out_stall      | o_alloc_offset, o_freed_size,
//          |           |                                | o_status
//
// Operation: one request at a time. The table is read one entry per cycle through the
// memory read port, then entries are moved one per cycle through the write port.
// Entries scanned plus entries moved never pass the segment count plus one.
// Reset clears the segment count and the control state; the table needs no clearing.
// A result waits in its output register while the result side stalls; the next request
// is taken meanwhile and held in its last cycle until the output register frees up.
module first_fit_offset_allocator #(
    parameter int unsigned MAX_SEGMENTS = 64,
    parameter int unsigned ADDR_WIDTH   = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_action,
    input  logic [31:0] i_req_size,
    input  logic [31:0] i_free_offset,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_alloc_offset,
    output logic [31:0] o_freed_size,
    output logic [1:0]  o_status
);

    localparam int unsigned FW = ffoa_pkg::FIELD_W;
    localparam int unsigned SW = ffoa_pkg::STATUS_W;
    localparam int unsigned IW = $clog2(MAX_SEGMENTS);
    localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
    localparam logic [FW:0] LIMIT = (FW+1)'(1) << ADDR_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASCAN,
        S_ADEC,
        S_ASHIFT,
        S_FSCAN,
        S_FSHIFT,
        S_FIN
    } t_state;

    // segment table
    logic [FW-1:0] mem_start [MAX_SEGMENTS];
    logic [FW-1:0] mem_size  [MAX_SEGMENTS];
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [FW-1:0] mem_wstart;
    logic [FW-1:0] mem_wsize;
    logic [FW-1:0] r_rd_start;
    logic [FW-1:0] r_rd_size;

    // control state
    t_state        r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx,   n_idx;
    logic [CW-1:0] r_ridx,  n_ridx;
    logic [CW-1:0] r_ins,   n_ins;
    logic [CW-1:0] r_left,  n_left;
    logic          r_dv,    n_dv;
    logic          r_out_valid, n_out_valid;

    // working payload
    logic [FW:0]   r_pos, n_pos;
    logic [FW-1:0] r_need, n_need;
    logic [FW-1:0] r_where, n_where;
    logic [FW-1:0] r_prev_start, n_prev_start;
    logic          r_have_prev, n_have_prev;
    logic [FW-1:0] r_brk_start, n_brk_start;
    logic          r_broke, n_broke;
    logic [FW-1:0] r_res_offset, n_res_offset;
    logic [FW-1:0] r_res_size, n_res_size;
    logic [SW-1:0] r_res_status, n_res_status;
    logic [FW-1:0] r_out_offset;
    logic [FW-1:0] r_out_size;
    logic [SW-1:0] r_out_status;
    logic          out_load;

    // datapath helpers
    logic [FW:0]   rd_start_x;
    logic [FW:0]   gap;
    logic [FW:0]   pos_sum;
    logic [FW+1:0] pos_end;
    logic          last_entry;
    logic          start_taken;
    logic          out_of_range;
    logic [CW-1:0] idx_up;
    logic [CW-1:0] idx_dn;

    assign rd_start_x   = {1'b0, r_rd_start};
    assign gap          = (rd_start_x >= r_pos) ? (rd_start_x - r_pos) : '0;
    assign pos_sum      = rd_start_x + {1'b0, r_rd_size};
    assign pos_end      = {1'b0, r_pos} + {2'b00, r_need};
    assign last_entry   = ((r_ridx + CW'(1)) == r_count);
    assign start_taken  = (r_have_prev && ({1'b0, r_prev_start} == r_pos)) ||
                          (r_broke && ({1'b0, r_brk_start} == r_pos));
    assign out_of_range = (r_pos >= LIMIT) || (pos_end > {1'b0, LIMIT});
    assign idx_up       = r_ridx + CW'(1);
    assign idx_dn       = r_ridx - CW'(1);

    // sequence the scan, decision and move phases
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_idx        = r_idx;
        n_ridx       = r_ridx;
        n_ins        = r_ins;
        n_left       = r_left;
        n_dv         = 1'b0;
        n_out_valid  = r_out_valid && i_out_stall;
        n_pos        = r_pos;
        n_need       = r_need;
        n_where      = r_where;
        n_prev_start = r_prev_start;
        n_have_prev  = r_have_prev;
        n_brk_start  = r_brk_start;
        n_broke      = r_broke;
        n_res_offset = r_res_offset;
        n_res_size   = r_res_size;
        n_res_status = r_res_status;
        out_load     = 1'b0;
        mem_we       = 1'b0;
        mem_raddr    = r_idx[IW-1:0];
        mem_waddr    = idx_up[IW-1:0];
        mem_wstart   = r_rd_start;
        mem_wsize    = r_rd_size;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_need       = i_req_size;
                    n_where      = i_free_offset;
                    n_pos        = '0;
                    n_have_prev  = 1'b0;
                    n_broke      = 1'b0;
                    n_idx        = '0;
                    n_ins        = '0;
                    n_res_offset = '0;
                    n_res_size   = '0;
                    n_res_status = ffoa_pkg::ST_OK;
                    if (i_action == ffoa_pkg::ACT_FREE) begin
                        if (r_count == '0) begin
                            n_res_status = ffoa_pkg::ST_NOT_FOUND;
                            n_state      = S_FIN;
                        end else begin
                            n_state = S_FSCAN;
                        end
                    end else begin
                        n_state = (r_count == '0) ? S_ADEC : S_ASCAN;
                    end
                end
            end

            S_ASCAN: begin
                // stream reads, one entry a cycle
                if (r_idx < r_count) begin
                    n_idx  = r_idx + CW'(1);
                    n_dv   = 1'b1;
                    n_ridx = r_idx;
                end
                // stop at the first gap that fits, else advance past the segment
                if (r_dv) begin
                    if (gap >= {1'b0, r_need}) begin
                        n_ins       = r_ridx;
                        n_broke     = 1'b1;
                        n_brk_start = r_rd_start;
                        n_state     = S_ADEC;
                    end else begin
                        n_pos        = pos_sum;
                        n_prev_start = r_rd_start;
                        n_have_prev  = 1'b1;
                        if (last_entry) begin
                            n_ins   = r_count;
                            n_state = S_ADEC;
                        end
                    end
                end
            end

            S_ADEC: begin
                // start already held by a segment: report it, add nothing
                if (start_taken) begin
                    n_res_offset = r_pos[FW-1:0];
                    n_state      = S_FIN;
                end else if (out_of_range) begin
                    n_res_status = ffoa_pkg::ST_RANGE;
                    n_state      = S_FIN;
                end else if (r_count >= CW'(MAX_SEGMENTS)) begin
                    n_res_status = ffoa_pkg::ST_FULL;
                    n_state      = S_FIN;
                end else begin
                    n_res_offset = r_pos[FW-1:0];
                    n_left       = r_count - r_ins;
                    n_idx        = r_count - CW'(1);
                    n_state      = S_ASHIFT;
                end
            end

            S_ASHIFT: begin
                // move entries up by one, top first
                if (r_left != '0) begin
                    n_idx  = r_idx - CW'(1);
                    n_left = r_left - CW'(1);
                    n_dv   = 1'b1;
                    n_ridx = r_idx;
                end
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_up[IW-1:0];
                end else if (r_left == '0) begin
                    // drop the new segment into the opened slot
                    mem_we     = 1'b1;
                    mem_waddr  = r_ins[IW-1:0];
                    mem_wstart = r_pos[FW-1:0];
                    mem_wsize  = r_need;
                    n_count    = r_count + CW'(1);
                    n_state    = S_FIN;
                end
            end

            S_FSCAN: begin
                if (r_idx < r_count) begin
                    n_idx  = r_idx + CW'(1);
                    n_dv   = 1'b1;
                    n_ridx = r_idx;
                end
                // look for the exact start
                if (r_dv) begin
                    if (r_rd_start == r_where) begin
                        n_res_size = r_rd_size;
                        n_ins      = r_ridx;
                        n_left     = r_count - r_ridx - CW'(1);
                        n_idx      = r_ridx + CW'(1);
                        n_dv       = 1'b0;
                        n_state    = S_FSHIFT;
                    end else if (last_entry) begin
                        n_res_status = ffoa_pkg::ST_NOT_FOUND;
                        n_state      = S_FIN;
                    end
                end
            end

            S_FSHIFT: begin
                // close the hole: move entries down by one, bottom first
                if (r_left != '0) begin
                    n_idx  = r_idx + CW'(1);
                    n_left = r_left - CW'(1);
                    n_dv   = 1'b1;
                    n_ridx = r_idx;
                end
                if (r_dv) begin
                    mem_we    = 1'b1;
                    mem_waddr = idx_dn[IW-1:0];
                end else if (r_left == '0) begin
                    n_count = r_count - CW'(1);
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                // hold until the output register is free
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_ridx      <= '0;
            r_ins       <= '0;
            r_left      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_idx       <= n_idx;
            r_ridx      <= n_ridx;
            r_ins       <= n_ins;
            r_left      <= n_left;
            r_dv        <= n_dv;
            r_out_valid <= n_out_valid;
        end
    end

    // working and result payload
    always_ff @(posedge i_clk) begin
        r_pos        <= n_pos;
        r_need       <= n_need;
        r_where      <= n_where;
        r_prev_start <= n_prev_start;
        r_have_prev  <= n_have_prev;
        r_brk_start  <= n_brk_start;
        r_broke      <= n_broke;
        r_res_offset <= n_res_offset;
        r_res_size   <= n_res_size;
        r_res_status <= n_res_status;
        if (out_load) begin
            r_out_offset <= r_res_offset;
            r_out_size   <= r_res_size;
            r_out_status <= r_res_status;
        end
    end

    // segment table memories, registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_start[mem_waddr] <= mem_wstart;
            mem_size[mem_waddr]  <= mem_wsize;
        end
        r_rd_start <= mem_start[mem_raddr];
        r_rd_size  <= mem_size[mem_raddr];
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_alloc_offset = r_out_offset;
    assign o_freed_size   = r_out_size;
    assign o_status       = r_out_status;

    // segment count never passes the table depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_SEGMENTS))
        else $error("segment count beyond table depth");

    // scans only read the table
    a_scan_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ASCAN || r_state == S_FSCAN) |-> !mem_we)
        else $error("table written during a scan");

    // the count moves only at the end of a move phase
    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> ($past(r_state) == S_ASHIFT || $past(r_state) == S_FSHIFT))
        else $error("segment count changed outside a move phase");

    // a new result is loaded only when the output register is free
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> (!r_out_valid || !i_out_stall))
        else $error("result overwritten while stalled");

endmodule

[tb/tb_top.sv]
// Testbench for the first-fit offset allocator: directed and random allocate/free words.
// A scoreboard class predicts each result from its own copy of the segment table.
// Depends on ffoa_pkg and first_fit_offset_allocator.
`timescale 1ns / 1ps

module tb_top;

    localparam int unsigned TABLE_DEPTH   = 64;
    localparam int unsigned ADDR_W        = 32;
    localparam int unsigned RANDOM_ITEMS  = 1600;
    localparam int unsigned WATCHDOG_MAX  = 4000;
    localparam int unsigned DRAIN_CYCLES  = 2 * TABLE_DEPTH + 20;
    localparam int unsigned HOLD_AT       = 12000;
    localparam int unsigned HOLD_LEN      = 600;
    localparam int unsigned CALM_FROM     = 30000;
    localparam int unsigned CALM_TO       = 45000;

    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic [1:0]  status;
    } t_alloc_result;

    // Segment table mirror and the queue of results still owed by the block
    class t_alloc_scoreboard;
        logic [31:0]   seg_base [TABLE_DEPTH];
        logic [31:0]   seg_len  [TABLE_DEPTH];
        int unsigned   live;
        int unsigned   peak;
        t_alloc_result owed [$];
        int unsigned   errors;
        int unsigned   checked;
        int unsigned   n_full;
        int unsigned   n_range;
        int unsigned   n_missing;
        int unsigned   n_shared;

        // Apply one accepted request word to the table and queue its result
        function void note_request(logic act, logic [31:0] need, logic [31:0] where);
            logic [63:0]   pos;
            logic [63:0]   gap;
            logic [63:0]   span;
            logic [63:0]   limit;
            int unsigned   idx;
            int unsigned   k;
            bit            taken;
            t_alloc_result res;
            res   = '0;
            limit = 64'd1 << ADDR_W;
            if (act == ffoa_pkg::ACT_ALLOC) begin
                // walk the gaps from address zero, first one that fits wins
                span = {32'd0, need};
                pos  = '0;
                idx  = 0;
                while (idx < live) begin
                    gap = ({32'd0, seg_base[idx]} >= pos) ? {32'd0, seg_base[idx]} - pos : '0;
                    if (gap >= span) break;
                    pos = {32'd0, seg_base[idx]} + {32'd0, seg_len[idx]};
                    idx++;
                end
                taken = 1'b0;
                for (k = 0; k < live; k++) begin
                    if ({32'd0, seg_base[k]} == pos) taken = 1'b1;
                end
                if (taken) begin
                    res.status = ffoa_pkg::ST_OK;
                    res.offset = pos[31:0];
                    n_shared++;
                end else if (pos >= limit || pos + span > limit) begin
                    res.status = ffoa_pkg::ST_RANGE;
                    n_range++;
                end else if (live >= TABLE_DEPTH) begin
                    res.status = ffoa_pkg::ST_FULL;
                    n_full++;
                end else begin
                    // open a slot at idx and record the new segment
                    for (k = live; k > idx; k--) begin
                        seg_base[k] = seg_base[k - 1];
                        seg_len[k]  = seg_len[k - 1];
                    end
                    seg_base[idx] = pos[31:0];
                    seg_len[idx]  = need;
                    live++;
                    if (live > peak) peak = live;
                    res.status = ffoa_pkg::ST_OK;
                    res.offset = pos[31:0];
                end
            end else begin
                // exact start lookup, then close the hole
                idx = 0;
                while (idx < live && seg_base[idx] != where) idx++;
                if (idx >= live) begin
                    res.status = ffoa_pkg::ST_NOT_FOUND;
                    n_missing++;
                end else begin
                    res.size = seg_len[idx];
                    for (k = idx; k + 1 < live; k++) begin
                        seg_base[k] = seg_base[k + 1];
                        seg_len[k]  = seg_len[k + 1];
                    end
                    live--;
                    res.status = ffoa_pkg::ST_OK;
                end
            end
            owed.insert(owed.size(), res);
        endfunction

        // Compare one result word with the oldest owed result
        function void check_result(logic [31:0] offset, logic [31:0] size, logic [1:0] status);
            t_alloc_result want;
            checked++;
            if (owed.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got offset %h size %h status %0d",
                         $time, offset, size, status);
                return;
            end
            want = owed.pop_front();
            if (offset !== want.offset) begin
                errors++;
                $display("%0t: alloc_offset mismatch, expected %h, got %h",
                         $time, want.offset, offset);
            end
            if (size !== want.size) begin
                errors++;
                $display("%0t: freed_size mismatch, expected %h, got %h",
                         $time, want.size, size);
            end
            if (status !== want.status) begin
                errors++;
                $display("%0t: status mismatch, expected %0d, got %0d",
                         $time, want.status, status);
            end
        endfunction
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_in_valid    = 1'b0;
    logic        i_action      = ffoa_pkg::ACT_ALLOC;
    logic [31:0] i_req_size    = '0;
    logic [31:0] i_free_offset = '0;
    logic        i_out_stall   = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_alloc_offset;
    logic [31:0] o_freed_size;
    logic [1:0]  o_status;

    t_alloc_scoreboard board = new();
    int unsigned       words_sent = 0;
    int unsigned       rx_cycle   = 0;
    int unsigned       quiet_run  = 0;

    first_fit_offset_allocator #(
        .MAX_SEGMENTS (TABLE_DEPTH),
        .ADDR_WIDTH   (ADDR_W)
    ) i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_action       (i_action),
        .i_req_size     (i_req_size),
        .i_free_offset  (i_free_offset),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_alloc_offset (o_alloc_offset),
        .o_freed_size   (o_freed_size),
        .o_status       (o_status)
    );

    always #4 i_clk = ~i_clk;

    // Offer one request word and hold it until the block takes it
    task automatic offer(input logic act, input logic [31:0] need, input logic [31:0] where);
        i_in_valid    <= 1'b1;
        i_action      <= act;
        i_req_size    <= need;
        i_free_offset <= where;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        board.note_request(act, need, where);
        words_sent++;
    endtask

    // Result side: check accepted words, drive stall at random with one long hold-off and one calm stretch
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            board.check_result(o_alloc_offset, o_freed_size, o_status);
        rx_cycle <= rx_cycle + 1;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (rx_cycle >= HOLD_AT && rx_cycle < HOLD_AT + HOLD_LEN) begin
            i_out_stall <= 1'b1;
        end else if (rx_cycle >= CALM_FROM && rx_cycle < CALM_TO) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 6);
        end
    end

    // Watchdog: end the run when no word moves on either side for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_run <= 0;
        else
            quiet_run <= quiet_run + 1;
        if (quiet_run >= WATCHDOG_MAX) begin
            $display("%0t: no handshake for %0d cycles", $time, quiet_run);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        int unsigned n;
        int unsigned phase;
        int unsigned alloc_pct;
        int unsigned pick;
        logic        act;
        logic [31:0] need;
        logic [31:0] where;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, top of the address range, zero sizes, first fit
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd0);
        offer(ffoa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, $urandom);
        offer(ffoa_pkg::ACT_ALLOC, 32'd1, 32'hFFFF_FFFF);
        offer(ffoa_pkg::ACT_ALLOC, 32'd1, 32'd0);
        offer(ffoa_pkg::ACT_ALLOC, 32'd0, $urandom);
        offer(ffoa_pkg::ACT_FREE,  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer(ffoa_pkg::ACT_FREE,  32'd0, 32'd0);
        offer(ffoa_pkg::ACT_ALLOC, 32'd0, $urandom);
        offer(ffoa_pkg::ACT_ALLOC, 32'd0, $urandom);
        offer(ffoa_pkg::ACT_ALLOC, 32'd16, $urandom);
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd0);
        offer(ffoa_pkg::ACT_ALLOC, 32'd16, $urandom);
        offer(ffoa_pkg::ACT_ALLOC, 32'd8, $urandom);
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd0);
        offer(ffoa_pkg::ACT_ALLOC, 32'd4, $urandom);
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd12345);
        offer(ffoa_pkg::ACT_ALLOC, 32'hFFFF_FFFF, $urandom);
        offer(ffoa_pkg::ACT_ALLOC, 32'hFFFF_FFE8, $urandom);
        offer(ffoa_pkg::ACT_ALLOC, 32'h8000_0000, $urandom);
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd24);
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd16);
        offer(ffoa_pkg::ACT_FREE,  $urandom, 32'd0);

        // Random: fill, churn and drain phases so the table runs full and empty
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            phase     = n % 350;
            alloc_pct = (phase < 150) ? 85 : (phase < 250) ? 50 : 20;
            act       = ($urandom_range(99) < alloc_pct) ? ffoa_pkg::ACT_ALLOC
                                                         : ffoa_pkg::ACT_FREE;
            need      = $urandom;
            where     = $urandom;
            pick      = $urandom_range(99);
            if (act == ffoa_pkg::ACT_ALLOC) begin
                if (pick < 8)
                    need = 32'd0;
                else if (pick < 78)
                    need = $urandom_range(64, 1);
                else if (pick < 88)
                    need = $urandom_range(4096, 65);
                else if (pick >= 94)
                    need = 32'hFFFF_FFFF - $urandom_range(255);
            end else if (board.live > 0 && pick < 80) begin
                where = board.seg_base[$urandom_range(board.live - 1)];
                // near miss: one word off a live start
                if (pick >= 70) where = ($urandom_range(1)) ? where + 1 : where - 1;
            end else if (pick < 85) begin
                where = 32'd0;
            end
            offer(act, need, where);
            // idle now and then, except across one long stretch
            if ((n < 600 || n >= 900) && $urandom_range(99) < 6) begin
                i_in_valid <= 1'b0;
                repeat ($urandom_range(5, 1)) @(posedge i_clk);
            end
        end
        i_in_valid <= 1'b0;

        // Drain: wait for every owed result, then allow for a late extra word
        while (board.owed.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d requests, checked %0d results, peak table use %0d of %0d",
                 words_sent, board.checked, board.peak, TABLE_DEPTH);
        $display("Seen: %0d table full, %0d out of range, %0d missing frees, %0d shared starts",
                 board.n_full, board.n_range, board.n_missing, board.n_shared);
        if (board.errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches", board.errors);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
